>>> hdl/binary_to_decimal_ascii_top_defines.svh
// Assertion macros shared by the checker of the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define B2DA_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define B2DA_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/b2da_pkg.sv
package b2da_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_FIELD_WIDTH = 64;

    // Decimal digits needed for VALUE_WIDTH bits, floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH = 4 * NUM_DIGITS;
    localparam int SHIFT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_WIDTH = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [IN_FIELD_WIDTH-1:0] value_bits;
        logic                      is_signed;
    } req_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } rsp_word_t;

    // Hand-over from the shift-and-add converter to the character emitter.
    typedef struct packed {
        logic                 done;
        logic                 neg;
        logic [BCD_WIDTH-1:0] digits;
    } bcd_result_t;

endpackage

>>> hdl/b2da_dabble.sv
module b2da_dabble
    import b2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] mag,
    input  logic                   neg,
    output bcd_result_t            result,
    output logic                   busy
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [SHIFT_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0]     bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]       bcd_reg, bcd_next;
    logic                       neg_reg, neg_next;
    logic [BCD_WIDTH-1:0]       bcd_adj;

    // Every digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SHIFT_CNT_WIDTH'(VALUE_WIDTH);
            bin_next  = mag;
            bcd_next  = '0;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - SHIFT_CNT_WIDTH'(1);
            if (cnt_reg == SHIFT_CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign result.done   = done_reg;
    assign result.neg    = neg_reg;
    assign result.digits = bcd_reg;
    assign busy          = busy_reg | done_reg;

endmodule

>>> hdl/b2da_emit.sv
module b2da_emit
    import b2da_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bcd_result_t result,
    output logic        busy,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp
);

    logic                     busy_reg, busy_next;
    logic                     started_reg, started_next;
    logic                     minus_reg, minus_next;
    logic [DIG_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [BCD_WIDTH-1:0]     dig_reg, dig_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_word_t                rsp_reg, rsp_next;
    logic                     advance;
    logic [3:0]               top_digit;

    assign advance   = busy_reg && (!rsp_valid_reg || rsp_ready);
    assign top_digit = dig_reg[BCD_WIDTH-1 -: 4];

    always_comb
    begin
        busy_next      = busy_reg;
        started_next   = started_reg;
        minus_next     = minus_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (result.done)
        begin
            busy_next    = 1'b1;
            started_next = 1'b0;
            minus_next   = result.neg;
            cnt_next     = DIG_CNT_WIDTH'(NUM_DIGITS);
            dig_next     = result.digits;
        end
        else if (advance)
        begin
            if (minus_reg)
            begin
                minus_next     = 1'b0;
                rsp_next       = '{out_char: CHAR_MINUS, last: 1'b0};
                rsp_valid_next = 1'b1;
            end
            else
            begin
                dig_next = {dig_reg[BCD_WIDTH-5:0], 4'd0};
                cnt_next = cnt_reg - DIG_CNT_WIDTH'(1);
                // Leading zeros are dropped, but the final digit always goes out.
                if (started_reg || top_digit != 4'd0 || cnt_reg == DIG_CNT_WIDTH'(1))
                begin
                    started_next   = 1'b1;
                    rsp_next       = '{out_char: CHAR_ZERO + {4'd0, top_digit},
                                       last: (cnt_reg == DIG_CNT_WIDTH'(1))};
                    rsp_valid_next = 1'b1;
                end
                if (cnt_reg == DIG_CNT_WIDTH'(1))
                    busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            started_reg   <= 1'b0;
            minus_reg     <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            started_reg   <= started_next;
            minus_reg     <= minus_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        rsp_reg <= rsp_next;
    end

    assign busy      = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hdl/binary_to_decimal_ascii_top.sv
// Binary to decimal text converter.
// The req channel carries one word per number: a 64-bit pattern and a flag
// that reads it as two's complement or unsigned. The rsp channel returns the
// decimal text one ASCII character per word, most significant first, with a
// leading minus for negative signed values and last set on the final digit.
// Zero gives the single character '0'.
// An accepted word first runs through a shift-and-add-3 converter that takes
// one magnitude bit per cycle. The emitter then walks the 20 BCD digits, one
// per cycle while the receiver does not stall, skipping leading zeros without
// output, and sends the minus sign ahead of the digits.
// One number is in work at a time: req_ready drops at acceptance and rises
// again once the last character sits in the output register, so the next
// word may be taken while that character still waits for the receiver.
// A stall on rsp simply holds the emitter; nothing is lost or repeated.
// Reset empties the output register and returns both units to idle.
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    logic                   accept;
    logic                   dab_busy;
    logic                   emit_busy;
    logic [VALUE_WIDTH-1:0] value;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    bcd_result_t            bcd_result;

    // Only the low VALUE_WIDTH bits take part; the top one is the sign when
    // the word is signed. The magnitude negate wraps, so the most negative
    // value comes out exact.
    assign value     = req.value_bits[VALUE_WIDTH-1:0];
    assign neg       = req.is_signed && value[VALUE_WIDTH-1];
    assign mag       = neg ? (~value + VALUE_WIDTH'(1)) : value;
    assign req_ready = !dab_busy && !emit_busy;
    assign accept    = req_valid && req_ready;

    b2da_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .neg    (neg),
        .result (bcd_result),
        .busy   (dab_busy)
    );

    b2da_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (bcd_result),
        .busy      (emit_busy),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> hdl/b2da_checker.sv
`include "binary_to_decimal_ascii_top_defines.svh"

module b2da_checker
    import b2da_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp
);

    logic req_accept;
    logic rsp_stall;
    logic char_ok;

    assign req_accept = req_valid && req_ready;
    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign char_ok    = (rsp.out_char == CHAR_MINUS) ||
                        ((rsp.out_char >= CHAR_ZERO) && (rsp.out_char <= CHAR_ZERO + 8'd9));

    `B2DA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid, "rsp word dropped")
    `B2DA_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_ready, "ready after accept")
    `B2DA_ASSERT_NOW(a_minus_not_last, rsp_valid && rsp.out_char == CHAR_MINUS, !rsp.last, "minus ends a number")
    `B2DA_ASSERT_NOW(a_no_overlap, rsp_valid && !rsp.last, !req_ready, "ready during text")
    `B2DA_ASSERT_NOW(a_char_legal, rsp_valid, char_ok, "bad character")

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (.*);
